/* hdl/bc2_pkg.sv */
// ----------------------------------------------------------------------------
// bc2_pkg
// Shared types and constants for the BC2 (DXT3) block decoder pipeline.
// ----------------------------------------------------------------------------
package bc2_pkg;

  // endpoint widening: red and blue from 5 bits, green from 6 bits
  localparam int unsigned W5_MUL = 527;
  localparam int unsigned W5_ADD = 23;
  localparam int unsigned W6_MUL = 259;
  localparam int unsigned W6_ADD = 33;
  localparam logic [4:0]  MASK5  = 5'h1F;
  localparam logic [5:0]  MASK6  = 6'h3F;

  // divide by three through a reciprocal, exact for dividends below 2048
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;

  // alpha nibble replication masks
  localparam logic [7:0] NIB_HI = 8'hF0;
  localparam logic [7:0] NIB_LO = 8'h0F;

  // 24-bit color, red in 7:0, green in 15:8, blue in 23:16
  typedef logic [23:0] rgb_t;

  // stage one result: widened endpoints plus raw per-texel bits
  typedef struct packed {
    logic [63:0] alpha;
    logic [31:0] codes;
    rgb_t        e1;
    rgb_t        e0;
  } bc2_ends_t;

  // stage two result: full palette plus raw per-texel bits
  typedef struct packed {
    logic [63:0]     alpha;
    logic [31:0]     codes;
    rgb_t [3:0]      pal;
  } bc2_pal_t;

  // one decoded row
  typedef struct packed {
    logic [31:0] texel_three;
    logic [31:0] texel_two;
    logic [31:0] texel_one;
    logic [31:0] texel_zero;
    logic [1:0]  row_index;
  } bc2_row_t;

endpackage

/* hdl/bc2_widen.sv */
// ----------------------------------------------------------------------------
// bc2_widen
// First pipeline stage: splits the RGB565 endpoints and widens them to
// 8 bits per channel with the rounding multipliers.
// ----------------------------------------------------------------------------
module bc2_widen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        alpha_bits,
  input  logic [63:0]        color_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output bc2_pkg::bc2_ends_t out_data
);

  logic               valid_r;
  logic               valid_nxt;
  bc2_pkg::bc2_ends_t data_r;
  bc2_pkg::bc2_ends_t data_nxt;

  // 5-bit channel to 8 bits
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [13:0] p;
    p = 14'(v & bc2_pkg::MASK5) * 14'(bc2_pkg::W5_MUL) + 14'(bc2_pkg::W5_ADD);
    return p[13:6];
  endfunction

  // 6-bit channel to 8 bits
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [13:0] p;
    p = 14'(v & bc2_pkg::MASK6) * 14'(bc2_pkg::W6_MUL) + 14'(bc2_pkg::W6_ADD);
    return p[13:6];
  endfunction

  // split one 565 word into packed rgb
  function automatic bc2_pkg::rgb_t split565(input logic [15:0] c);
    return {widen5(c[4:0]), widen6(c[10:5]), widen5(c[15:11])};
  endfunction

  assign in_ready = !valid_r || out_ready;

  // next stage contents
  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.alpha = alpha_bits;
    data_nxt.codes = color_bits[63:32];
    data_nxt.e0    = split565(color_bits[15:0]);
    data_nxt.e1    = split565(color_bits[31:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hdl/bc2_palette.sv */
// ----------------------------------------------------------------------------
// bc2_palette
// Second pipeline stage: builds the four-entry palette, the two blended
// entries with truncating division by three.
// ----------------------------------------------------------------------------
module bc2_palette (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bc2_pkg::bc2_ends_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bc2_pkg::bc2_pal_t  out_data
);

  logic              valid_r;
  logic              valid_nxt;
  bc2_pkg::bc2_pal_t data_r;
  bc2_pkg::bc2_pal_t data_nxt;

  // floor(x / 3) for x up to 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'(bc2_pkg::DIV3_MUL);
    return p[bc2_pkg::DIV3_SHIFT +: 8];
  endfunction

  assign in_ready = !valid_r || out_ready;

  // palette per channel
  always_comb begin
    logic [9:0] a;
    logic [9:0] b;
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.alpha  = in_data.alpha;
    data_nxt.codes  = in_data.codes;
    data_nxt.pal[0] = in_data.e0;
    data_nxt.pal[1] = in_data.e1;
    for (int ch = 0; ch < 3; ch++) begin
      a = 10'(in_data.e0[8*ch +: 8]);
      b = 10'(in_data.e1[8*ch +: 8]);
      data_nxt.pal[2][8*ch +: 8] = div3((a << 1) + b);
      data_nxt.pal[3][8*ch +: 8] = div3(a + (b << 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hdl/bc2_row_out.sv */
// ----------------------------------------------------------------------------
// bc2_row_out
// Final stages: holds one palettized block, steps through its four rows
// and assembles the RGBA texels of each row into the output register.
// ----------------------------------------------------------------------------
module bc2_row_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bc2_pkg::bc2_pal_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bc2_pkg::bc2_row_t out_data,
  output logic              out_last
);

  localparam logic [1:0] LAST_ROW = 2'd3;

  bc2_pkg::bc2_pal_t blk_r;
  logic              blk_valid_r;
  logic              blk_valid_nxt;
  logic [1:0]        row_r;
  logic [1:0]        row_nxt;
  logic              ovalid_r;
  logic              ovalid_nxt;
  bc2_pkg::bc2_row_t orow_r;
  bc2_pkg::bc2_row_t orow_nxt;
  logic              olast_r;
  logic              emit;
  logic              take;

  // one row leaves the block register when the output register frees up
  assign emit     = blk_valid_r && (!ovalid_r || out_ready);
  assign in_ready = !blk_valid_r || (emit && row_r == LAST_ROW);
  assign take     = in_valid && in_ready;

  // texel assembly for the current row
  always_comb begin
    logic [7:0]  codes_row;
    logic [15:0] alpha_row;
    logic [1:0]  code;
    logic [7:0]  a8;
    logic [31:0] texel [4];
    codes_row = blk_r.codes[{row_r, 3'b000} +: 8];
    alpha_row = blk_r.alpha[{row_r, 4'b0000} +: 16];
    for (int col = 0; col < 4; col++) begin
      code = codes_row[2*col +: 2];
      a8   = ({4'b0000, alpha_row[4*col +: 4]} << 4) & bc2_pkg::NIB_HI;
      a8   = a8 | ({4'b0000, alpha_row[4*col +: 4]} & bc2_pkg::NIB_LO);
      texel[col] = {a8, blk_r.pal[code]};
    end
    orow_nxt.row_index   = row_r;
    orow_nxt.texel_zero  = texel[0];
    orow_nxt.texel_one   = texel[1];
    orow_nxt.texel_two   = texel[2];
    orow_nxt.texel_three = texel[3];
  end

  // row counter, block and output valid flags
  always_comb begin
    blk_valid_nxt = blk_valid_r;
    row_nxt       = row_r;
    if (emit) begin
      row_nxt = row_r + 2'd1;
      if (row_r == LAST_ROW) begin
        blk_valid_nxt = 1'b0;
      end
    end
    if (take) begin
      blk_valid_nxt = 1'b1;
      row_nxt       = 2'd0;
    end
    ovalid_nxt = ovalid_r;
    if (!ovalid_r || out_ready) begin
      ovalid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      row_r       <= 2'd0;
      ovalid_r    <= 1'b0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
      row_r       <= row_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      blk_r <= in_data;
    end
    if (emit) begin
      orow_r  <= orow_nxt;
      olast_r <= (row_r == LAST_ROW);
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = orow_r;
  assign out_last  = olast_r;

endmodule

/* hdl/bc2_block_decoder_unit.sv */
// ----------------------------------------------------------------------------
// bc2_block_decoder_unit
// BC2 (DXT3) texture block decoder: one 16-byte block in, four rows of
// four RGBA texels out, top row first.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  in_*    | slave     | one compressed block (alpha half, color half)
//  out_*   | master    | one decoded row, tlast on the fourth row
//
//  the row stepper sends one row per cycle from its block register while the
//  output is not stalled, and takes the next block as it sends the last row;
//  a block passes widen, palette, block and output registers to the first row.
//  reset clears only the valid flags and the row counter.
//  a stall on the output holds every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bc2_block_decoder_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // alpha_bits [63:0], color_bits [127:64]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index [1:0], texel_zero [33:2], texel_one [65:34],
  // texel_two [97:66], texel_three [129:98], zero fill [135:130]
  output logic [135:0] out_tdata,
  output logic         out_tlast
);

  logic               s1_valid;
  logic               s1_ready;
  bc2_pkg::bc2_ends_t s1_data;
  logic               s2_valid;
  logic               s2_ready;
  bc2_pkg::bc2_pal_t  s2_data;
  bc2_pkg::bc2_row_t  row_data;

  // endpoint widening
  bc2_widen u_widen (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .alpha_bits (in_tdata[63:0]),
    .color_bits (in_tdata[127:64]),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  // palette build
  bc2_palette u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // row stepping and texel assembly
  bc2_row_out u_row_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (row_data),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'b000000, row_data};

endmodule

/* sim/bc2_row_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bc2_row_checker
// Watches both streams of the BC2 block decoder. Every accepted block is
// decoded here into its four expected rows. Each accepted row is compared
// field by field with the oldest expected row, and mismatches are counted.
// ----------------------------------------------------------------------------
module bc2_row_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // alpha_bits [63:0], color_bits [127:64]
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // row_index [1:0], texel_zero [33:2], texel_one [65:34],
  // texel_two [97:66], texel_three [129:98], zero fill [135:130]
  input  logic [135:0] out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           rows_pending
);

  // one decoded row as it should leave the block
  typedef struct packed {
    logic [1:0]       row_index;
    logic [3:0][31:0] texels;
    logic             last_row;
  } row_expect_t;

  row_expect_t expected_rows[$];
  int          mismatches = 0;
  string       texel_names [4] = '{"texel_zero", "texel_one", "texel_two", "texel_three"};

  // 5-bit channel to 8 bits, rounding multiply
  function automatic logic [7:0] expand_five(input logic [4:0] v);
    int unsigned wide;
    wide = (int'(v) * bc2_pkg::W5_MUL + bc2_pkg::W5_ADD) >> 6;
    return 8'(wide);
  endfunction

  // 6-bit channel to 8 bits, rounding multiply
  function automatic logic [7:0] expand_six(input logic [5:0] v);
    int unsigned wide;
    wide = (int'(v) * bc2_pkg::W6_MUL + bc2_pkg::W6_ADD) >> 6;
    return 8'(wide);
  endfunction

  // decode one block into its four rows and queue them
  function automatic void predict_block_rows(input logic [63:0] alpha_bits,
                                             input logic [63:0] color_bits);
    logic [7:0]  end0 [3];
    logic [7:0]  end1 [3];
    logic [23:0] palette [4];
    int unsigned a;
    int unsigned b;
    int          t;
    logic [1:0]  code;
    logic [3:0]  nib;
    row_expect_t row_out;
    end0[0] = expand_five(color_bits[15:11]);
    end0[1] = expand_six(color_bits[10:5]);
    end0[2] = expand_five(color_bits[4:0]);
    end1[0] = expand_five(color_bits[31:27]);
    end1[1] = expand_six(color_bits[26:21]);
    end1[2] = expand_five(color_bits[20:16]);
    // four-color palette regardless of endpoint order, blends truncate
    for (int ch = 0; ch < 3; ch++) begin
      a = end0[ch];
      b = end1[ch];
      palette[0][8*ch +: 8] = 8'(a);
      palette[1][8*ch +: 8] = 8'(b);
      palette[2][8*ch +: 8] = 8'((2 * a + b) / 3);
      palette[3][8*ch +: 8] = 8'((a + 2 * b) / 3);
    end
    for (int r = 0; r < 4; r++) begin
      row_out.row_index = 2'(r);
      row_out.last_row  = (r == 3);
      for (int col = 0; col < 4; col++) begin
        t    = 4 * r + col;
        code = color_bits[32 + 2*t +: 2];
        nib  = alpha_bits[4*t +: 4];
        row_out.texels[col] = {nib, nib, palette[code]};
      end
      expected_rows.push_back(row_out);
    end
  endfunction

  // compare outgoing rows first, then queue rows for a new block
  always @(posedge clk) begin : row_monitor
    row_expect_t want;
    logic [31:0] got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_rows.size() == 0) begin
          $error("row transaction with nothing expected, row_index %0d", out_tdata[1:0]);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          if (out_tdata[1:0] !== want.row_index) begin
            $error("row_index expected %0d, got %0d", want.row_index, out_tdata[1:0]);
            mismatches++;
          end
          for (int k = 0; k < 4; k++) begin
            got = out_tdata[2 + 32*k +: 32];
            if (got !== want.texels[k]) begin
              $error("%s expected 0x%08h, got 0x%08h", texel_names[k], want.texels[k], got);
              mismatches++;
            end
          end
          if (out_tlast !== want.last_row) begin
            $error("last_row expected %0d, got %0d", want.last_row, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_block_rows(in_tdata[63:0], in_tdata[127:64]);
    end
    fail_count   <= mismatches;
    rows_pending <= expected_rows.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives compressed BC2 blocks into the decoder with random gaps and pulls
// decoded rows with random back-pressure, including one long hold-off that
// fills the pipeline. A side checker predicts and compares every row.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_BLOCKS = 180;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_OFF_LEN  = 150;
  localparam int HOLD_AFTER    = 40;
  localparam int DRAIN_CYCLES  = 10;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // alpha_bits [63:0], color_bits [127:64]
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // row_index [1:0], texel_zero [33:2], texel_one [65:34],
  // texel_two [97:66], texel_three [129:98], zero fill [135:130]
  logic [135:0] out_tdata;
  logic         out_tlast;

  int fail_count;
  int rows_pending;
  int blocks_sent = 0;
  bit hold_done   = 0;

  bc2_block_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  bc2_row_checker row_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // endpoint word: extremes and pure primaries mixed with random ones
  function automatic logic [15:0] pick_endpoint();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hF800;
      3: return 16'h07E0;
      4: return 16'h001F;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one block, hold until the transaction, then maybe idle
  task automatic send_block(input logic [63:0] alpha_bits, input logic [63:0] color_bits);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {color_bits, alpha_bits};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    blocks_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // stimulus, end of run and verdict
  initial begin
    logic [15:0] e0;
    logic [15:0] e1;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every palette code, both endpoint orders
    send_block(64'h0, 64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'h0, 64'h0000_0000_0000_FFFF);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_0000_FFFF);
    send_block(64'h0, 64'hAAAA_AAAA_0000_FFFF);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_FFFF);
    send_block(64'hFEDC_BA98_7654_3210, 64'hE4E4_E4E4_FFFF_0000);
    send_block(64'h0123_4567_89AB_CDEF, 64'hE4E4_E4E4_0000_FFFF);
    send_block(64'h8421_1248_8421_1248, 64'h1B1B_1B1B_07E0_F800);
    send_block(64'h5A5A_A5A5_5A5A_A5A5, 64'h1B1B_1B1B_F800_001F);
    send_block(64'h0F0F_F0F0_0F0F_F0F0, 64'hE4E4_E4E4_001F_07E0);
    send_block(64'h3C3C_C3C3_3C3C_C3C3, 64'h9C63_36C9_8410_8410);
    send_block(64'h7777_8888_7777_8888, 64'hE4E4_E4E4_0821_F7DE);
    send_block(64'hFFFF_0000_FFFF_0000, 64'h1B1B_1B1B_F7DE_0821);

    // random blocks, about a third with hand-picked endpoints
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      if ($urandom_range(0, 2) == 0) begin
        e0 = pick_endpoint();
        e1 = ($urandom_range(0, 3) == 0) ? e0 : pick_endpoint();
        send_block({$urandom, $urandom}, {32'($urandom), e1, e0});
      end else begin
        send_block({$urandom, $urandom}, {$urandom, $urandom});
      end
    end
    in_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    do @(posedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // row receiver: random back-pressure plus one long hold-off
  initial begin
    int pick;
    int span;
    logic level;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (!hold_done && blocks_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        level     = 1'b0;
        span      = HOLD_OFF_LEN;
      end else if (pick < 45) begin
        level = 1'b1;
        span  = $urandom_range(1, 24);
      end else if (pick < 90) begin
        level = 1'b0;
        span  = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        span  = $urandom_range(6, 30);
      end
      repeat (span) begin
        out_tready <= level;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
hdl/bc2_pkg.sv
hdl/bc2_widen.sv
hdl/bc2_palette.sv
hdl/bc2_row_out.sv
hdl/bc2_block_decoder_unit.sv
sim/bc2_row_checker.sv
sim/testbench.sv
